FILE: rtl/rgb_to_lab_pixel_converter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RGB to Lab pixel converter
// Clocked implication checks with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_LAB_PIXEL_CONVERTER_ASSERT_SVH
`define RGB_TO_LAB_PIXEL_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define R2L_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("r2l same-cycle check failed");

// Next-cycle implication.
`define R2L_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r2l next-cycle check failed");

`endif

FILE: rtl/r2l_pkg.sv
// ---------------------------------------------------------------------------
// r2l_pkg
// Types, constants and tables shared by the RGB to Lab converter files.
// ---------------------------------------------------------------------------
package r2l_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [10:0] t_lin;
    typedef logic [15:0] t_frac;
    typedef logic [45:0] t_cbrt_in;

    typedef struct packed {
        t_byte l;
        t_byte a;
        t_byte b;
    } t_lab;

    // Register stages from the input register to the saturation stage.
    localparam int PIPE_DEPTH  = 24;
    // One cube-root stage per result bit.
    localparam int CBRT_STEPS  = 16;

    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    localparam logic [11:0] MAT_COEF [3][3] = '{
        '{12'd778,  12'd1541, 12'd1777},
        '{12'd296,  12'd2929, 12'd871 },
        '{12'd3575, 12'd448,  12'd73  }
    };
    localparam logic [23:0] MAT_ROUND = 24'd2048;

    // Inputs at or below this level use the linear segment.
    localparam logic [10:0] LIN_LIMIT = 11'd18;

    localparam logic signed [25:0] L_SCALE = 26'sd296;
    localparam logic signed [25:0] A_SCALE = 26'sd500;
    localparam logic signed [25:0] B_SCALE = 26'sd200;
    // Offset, rounding half and chroma bias folded together.
    localparam logic signed [25:0] L_BIAS  = -26'sd1320550;
    localparam logic signed [25:0] AB_BIAS = 26'sd4210688;

    // Linear segment of the Lab companding curve, 15 fractional bits.
    localparam logic [12:0] LIN_LUT [19] = '{
        13'd4519, 13'd4644, 13'd4769, 13'd4894, 13'd5020, 13'd5145, 13'd5270,
        13'd5395, 13'd5520, 13'd5645, 13'd5770, 13'd5895, 13'd6020, 13'd6145,
        13'd6270, 13'd6395, 13'd6521, 13'd6646, 13'd6771
    };

    // sRGB decoding, 2040 stands for full scale.
    localparam logic [10:0] GAMMA_LUT [256] = '{
        11'd0, 11'd1, 11'd1, 11'd2, 11'd2, 11'd3, 11'd4, 11'd4,
        11'd5, 11'd6, 11'd6, 11'd7, 11'd8, 11'd8, 11'd9, 11'd10,
        11'd11, 11'd11, 11'd12, 11'd13, 11'd14, 11'd15, 11'd16, 11'd17,
        11'd19, 11'd20, 11'd21, 11'd22, 11'd24, 11'd25, 11'd26, 11'd28,
        11'd29, 11'd31, 11'd33, 11'd34, 11'd36, 11'd38, 11'd40, 11'd41,
        11'd43, 11'd45, 11'd47, 11'd49, 11'd51, 11'd54, 11'd56, 11'd58,
        11'd60, 11'd63, 11'd65, 11'd68, 11'd70, 11'd73, 11'd75, 11'd78,
        11'd81, 11'd83, 11'd86, 11'd89, 11'd92, 11'd95,
        11'd98, 11'd101, 11'd105, 11'd108, 11'd111, 11'd115, 11'd118, 11'd121,
        11'd125, 11'd129, 11'd132, 11'd136, 11'd140, 11'd144, 11'd147, 11'd151,
        11'd155, 11'd160, 11'd164, 11'd168, 11'd172, 11'd176, 11'd181, 11'd185,
        11'd190, 11'd194,
        11'd199, 11'd204, 11'd209, 11'd213, 11'd218, 11'd223, 11'd228, 11'd233,
        11'd239, 11'd244, 11'd249, 11'd255, 11'd260, 11'd265, 11'd271, 11'd277,
        11'd282, 11'd288, 11'd294, 11'd300, 11'd306, 11'd312, 11'd318, 11'd324,
        11'd331, 11'd337,
        11'd343, 11'd350, 11'd356, 11'd363, 11'd370, 11'd376, 11'd383, 11'd390,
        11'd397, 11'd404, 11'd411, 11'd418, 11'd426, 11'd433, 11'd440, 11'd448,
        11'd455, 11'd463, 11'd471, 11'd478, 11'd486, 11'd494, 11'd502, 11'd510,
        11'd518, 11'd527,
        11'd535, 11'd543, 11'd552, 11'd560, 11'd569, 11'd578, 11'd586, 11'd595,
        11'd604, 11'd613, 11'd622, 11'd631, 11'd641, 11'd650, 11'd659, 11'd669,
        11'd678, 11'd688, 11'd698, 11'd707, 11'd717, 11'd727, 11'd737, 11'd747,
        11'd757, 11'd768,
        11'd778, 11'd788, 11'd799, 11'd809, 11'd820, 11'd831, 11'd842, 11'd852,
        11'd863, 11'd875, 11'd886, 11'd897, 11'd908, 11'd920, 11'd931, 11'd943,
        11'd954, 11'd966, 11'd978, 11'd990, 11'd1002, 11'd1014, 11'd1026, 11'd1038,
        11'd1050, 11'd1063,
        11'd1075, 11'd1088, 11'd1101, 11'd1113, 11'd1126, 11'd1139, 11'd1152,
        11'd1165, 11'd1178, 11'd1192, 11'd1205, 11'd1218, 11'd1232, 11'd1245,
        11'd1259, 11'd1273, 11'd1287, 11'd1301, 11'd1315, 11'd1329, 11'd1343,
        11'd1357, 11'd1372, 11'd1386,
        11'd1401, 11'd1415, 11'd1430, 11'd1445, 11'd1460, 11'd1475, 11'd1490,
        11'd1505, 11'd1521, 11'd1536, 11'd1551, 11'd1567, 11'd1583, 11'd1598,
        11'd1614, 11'd1630, 11'd1646, 11'd1662, 11'd1678, 11'd1695, 11'd1711,
        11'd1728, 11'd1744, 11'd1761,
        11'd1778, 11'd1794, 11'd1811, 11'd1828, 11'd1846, 11'd1863, 11'd1880,
        11'd1897, 11'd1915, 11'd1933, 11'd1950, 11'd1968, 11'd1986, 11'd2004,
        11'd2022, 11'd2040
    };

endpackage

FILE: rtl/r2l_if.sv
// ---------------------------------------------------------------------------
// r2l_pix_if and r2l_lab_if
// Valid/ready channels for the pixel requests and the Lab results.
// ---------------------------------------------------------------------------
interface r2l_pix_if import r2l_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte byte_first;
    t_byte byte_second;
    t_byte byte_third;

    modport source (output valid, output byte_first, output byte_second,
                    output byte_third, input ready);
    modport sink   (input valid, input byte_first, input byte_second,
                    input byte_third, output ready);
endinterface

interface r2l_lab_if import r2l_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte lightness;
    t_byte green_red;
    t_byte blue_yellow;

    modport source (output valid, output lightness, output green_red,
                    output blue_yellow, input ready);
    modport sink   (input valid, input lightness, input green_red,
                    input blue_yellow, output ready);
endinterface

FILE: rtl/rgb_to_lab_pixel_converter.sv
// ---------------------------------------------------------------------------
// rgb_to_lab_pixel_converter: 8-bit sRGB pixel to 8-bit CIE Lab
// Throughput: one pixel per clock while the skid register is empty.
// The 16-stage cube-root pipeline sets the depth.
// Reset: synchronous active low; clears the valid bits, skid flag and order.
// ---------------------------------------------------------------------------
`include "rgb_to_lab_pixel_converter_assert.svh"

module rgb_to_lab_pixel_converter import r2l_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_wr_en,
    input  logic  i_cfg_wr_data,
    r2l_pix_if.sink   i_pix,
    r2l_lab_if.source o_lab
);

    // Pipeline map:
    //   S1      channel swap and sRGB decode through the gamma table
    //   S2      nine constant products of the color matrix
    //   S3      row sums, rounding and shift to X, Y, Z in 0..2040
    //   S4      radicand floor(v * 2^42 / 255) and the linear-segment tag
    //   S5-S20  cube root, one result bit per stage, three lanes
    //   S21     pick the cube root or the linear-segment value
    //   S22     chroma differences
    //   S23     constant scaling with offsets and rounding folded in
    //   S24     floor by 2^15 and saturation to 0..255
    // The whole pipeline advances on one enable. Behind it an output register
    // and a skid register absorb a stalled sink, so the enable comes from a
    // flop and never from the sink's ready.

    typedef struct packed {
        logic       lin;
        logic [4:0] idx;
    } t_tag;

    logic                  r_order;
    logic                  w_en;
    logic                  w_accept;
    logic                  w_push;
    logic                  w_take;
    logic [PIPE_DEPTH-1:0] r_vld;

    t_lin        r_lin   [0:2];
    logic [22:0] r_prod  [0:2][0:2];
    t_lin        r_xyz   [0:2];
    t_cbrt_in    r_rad   [0:2];
    t_tag        r_tag   [0:2];
    t_tag        r_tag_d [0:CBRT_STEPS-1][0:2];
    t_frac       w_root  [0:2];
    t_frac       r_f     [0:2];

    t_frac             r_fy;
    logic signed [16:0] r_dxy;
    logic signed [16:0] r_dyz;
    logic signed [25:0] r_lsum;
    logic signed [25:0] r_asum;
    logic signed [25:0] r_bsum;
    t_lab              r_lab;

    logic r_out_v;
    t_lab r_out;
    logic r_skid_v;
    t_lab r_skid;

    // floor(v * 2^42 / 255) for v in 0..2040. With v = 255q + r the result is
    // q * 2^42 + r * 4 * (2^40 - 1) / 255 + floor(4r / 255), and the middle
    // term is r repeated in five bytes, so no multiplier is needed.
    function automatic t_cbrt_in rad_of(input t_lin v);
        logic [3:0] q;
        t_lin       rem;
        logic [1:0] fr;
        q   = '0;
        rem = v;
        for (int k = 1; k <= 8; k++) begin
            if (v >= 11'(255 * k)) begin
                q   = 4'(k);
                rem = v - 11'(255 * k);
            end
        end
        fr = 2'(rem >= 11'd64) + 2'(rem >= 11'd128) + 2'(rem >= 11'd192);
        return {q, {5{rem[7:0]}}, fr};
    endfunction

    // The sum carries the value floor-shifted by 15 in bits 25..15.
    function automatic t_byte sat_u8(input logic signed [25:0] s);
        t_byte res;
        if (s[25]) begin
            res = '0;
        end else if (s[24] || s[23]) begin
            res = '1;
        end else begin
            res = s[22:15];
        end
        return res;
    endfunction

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_order <= i_cfg_wr_data;
        end
    end

    // Flow control. The pipeline stalls only while the skid register is full.
    // No request is taken while reset is held.
    assign w_en        = !r_skid_v;
    assign i_pix.ready = w_en && i_rst_n;
    assign w_accept    = i_pix.valid && w_en && i_rst_n;
    assign w_push      = w_en && r_vld[PIPE_DEPTH-1];
    assign w_take      = r_out_v && o_lab.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_accept};
        end
    end

    // S1: channel order and gamma decode.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lin[CH_G] <= GAMMA_LUT[i_pix.byte_second];
            if (r_order) begin
                r_lin[CH_R] <= GAMMA_LUT[i_pix.byte_third];
                r_lin[CH_B] <= GAMMA_LUT[i_pix.byte_first];
            end else begin
                r_lin[CH_R] <= GAMMA_LUT[i_pix.byte_first];
                r_lin[CH_B] <= GAMMA_LUT[i_pix.byte_third];
            end
        end
    end

    // S2 to S4: matrix, then radicand and linear-segment tag per axis.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[a][c] <= 23'(r_lin[c]) * 23'(MAT_COEF[a][c]);
                end
                r_xyz[a] <= t_lin'((24'(r_prod[a][0]) + 24'(r_prod[a][1])
                                    + 24'(r_prod[a][2]) + MAT_ROUND) >> 12);
                r_rad[a]     <= rad_of(r_xyz[a]);
                r_tag[a].lin <= r_xyz[a] <= LIN_LIMIT;
                r_tag[a].idx <= (r_xyz[a] <= LIN_LIMIT) ? r_xyz[a][4:0] : 5'd0;
            end
        end
    end

    // S5 to S20: cube roots, with the tags delayed alongside.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        r2l_cbrt u_cbrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (r_rad[a]),
            .o_root (w_root[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_tag_d[0][a] <= r_tag[a];
                for (int s = 1; s < CBRT_STEPS; s++) begin
                    r_tag_d[s][a] <= r_tag_d[s-1][a];
                end
            end
        end
    end

    // S21 to S24: companded values, Lab arithmetic and saturation.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                if (r_tag_d[CBRT_STEPS-1][a].lin) begin
                    r_f[a] <= t_frac'(LIN_LUT[r_tag_d[CBRT_STEPS-1][a].idx]);
                end else begin
                    r_f[a] <= w_root[a];
                end
            end
            r_fy  <= r_f[AX_Y];
            r_dxy <= $signed({1'b0, r_f[AX_X]}) - $signed({1'b0, r_f[AX_Y]});
            r_dyz <= $signed({1'b0, r_f[AX_Y]}) - $signed({1'b0, r_f[AX_Z]});

            r_lsum <= $signed({10'd0, r_fy}) * L_SCALE + L_BIAS;
            r_asum <= $signed({{9{r_dxy[16]}}, r_dxy}) * A_SCALE + AB_BIAS;
            r_bsum <= $signed({{9{r_dyz[16]}}, r_dyz}) * B_SCALE + AB_BIAS;

            r_lab.l <= sat_u8(r_lsum);
            r_lab.a <= sat_u8(r_asum);
            r_lab.b <= sat_u8(r_bsum);
        end
    end

    // Output register with skid. A result arriving while the output holds an
    // untaken one parks in the skid register, which then halts the pipeline
    // until the sink drains it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_push;
            end
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            r_out <= r_skid_v ? r_skid : r_lab;
        end else if (w_push) begin
            r_skid <= r_lab;
        end
    end

    assign o_lab.valid       = r_out_v;
    assign o_lab.lightness   = r_out.l;
    assign o_lab.green_red   = r_out.a;
    assign o_lab.blue_yellow = r_out.b;

    // The skid register only fills behind a held output.
    `R2L_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    // A stalled pipeline keeps every valid bit in place.
    `R2L_ASSERT_NEXT(a_stall_keeps_vld, i_clk, i_rst_n, !w_en, $stable(r_vld))
    // A result pushed into a blocked output must land in the skid register.
    `R2L_ASSERT_NEXT(a_push_to_skid, i_clk, i_rst_n, r_out_v && !o_lab.ready && w_push, r_skid_v)

endmodule

FILE: rtl/r2l_cbrt.sv
// ---------------------------------------------------------------------------
// r2l_cbrt
// Pipelined integer cube root, one result bit per register stage.
// ---------------------------------------------------------------------------
module r2l_cbrt import r2l_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_cbrt_in i_rad,
    output t_frac    o_root
);

    // Each stage keeps the remainder rad - n^3 together with 3n and 3n^2,
    // so a trial bit costs only shifted adds and one compare.
    logic [45:0] r_rem [0:CBRT_STEPS-2];
    logic [15:0] r_n   [0:CBRT_STEPS-1];
    logic [17:0] r_tn  [0:CBRT_STEPS-2];
    logic [33:0] r_tn2 [0:CBRT_STEPS-2];

    for (genvar s = 0; s < CBRT_STEPS; s++) begin : g_step
        localparam int K = CBRT_STEPS - 1 - s;

        logic [45:0] c_rem;
        logic [15:0] c_n;
        logic [17:0] c_tn;
        logic [33:0] c_tn2;
        logic [49:0] delta;
        logic        take;

        if (s == 0) begin : g_first
            assign c_rem = i_rad;
            assign c_n   = '0;
            assign c_tn  = '0;
            assign c_tn2 = '0;
        end else begin : g_next
            assign c_rem = r_rem[s-1];
            assign c_n   = r_n[s-1];
            assign c_tn  = r_tn[s-1];
            assign c_tn2 = r_tn2[s-1];
        end

        // (n + 2^K)^3 - n^3 = 3n^2 2^K + 3n 2^2K + 2^3K
        assign delta = (50'(c_tn2) << K) + (50'(c_tn) << (2 * K)) + (50'(1) << (3 * K));
        assign take  = delta <= 50'(c_rem);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s] <= take ? (c_n | (16'(1) << K)) : c_n;
            end
        end

        if (s < CBRT_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (take) begin
                        r_rem[s] <= c_rem - delta[45:0];
                        r_tn[s]  <= c_tn + (18'(3) << K);
                        r_tn2[s] <= c_tn2 + (34'(c_tn) << (K + 1)) + (34'(3) << (2 * K));
                    end else begin
                        r_rem[s] <= c_rem;
                        r_tn[s]  <= c_tn;
                        r_tn2[s] <= c_tn2;
                    end
                end
            end
        end
    end

    assign o_root = r_n[CBRT_STEPS-1];

endmodule
